// ===== rtl/lcar_pkg.sv =====
// Shared types and constants of the load cell converter reader.
package lcar_pkg;

  localparam int DataBits   = 24;
  localparam int MaxSamples = 1024;
  localparam int SumW       = 35;
  localparam int DivSteps   = SumW;
  localparam int DivCntW    = 6;
  localparam int ProdW      = 57;

  localparam logic [23:0] SignFlip = 24'h800000;

  // Register addresses (word index)
  localparam logic [2:0] RegChanB   = 3'd0;
  localparam logic [2:0] RegSamples = 3'd1;
  localparam logic [2:0] RegHalf    = 3'd2;
  localparam logic [2:0] RegTimeout = 3'd3;
  localparam logic [2:0] RegGap     = 3'd4;
  localparam logic [2:0] RegScale   = 3'd5;

  // Request codes
  localparam logic [1:0] ModeTick    = 2'd0;
  localparam logic [1:0] ModeMeasure = 2'd1;
  localparam logic [1:0] ModeTare    = 2'd2;
  localparam logic [1:0] ModeSpare   = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW  = 3'd3,
    PH_GAP  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    C_RUN = 3'd0,
    C_DIV = 3'd1,
    C_MUL = 3'd2,
    C_SAT = 3'd3,
    C_FIN = 3'd4
  } ctrl_state_t;

  typedef struct packed {
    logic               use_channel_b;
    logic [10:0]        sample_count;
    logic [9:0]         half_period_ticks;
    logic [19:0]        ready_timeout_ticks;
    logic [19:0]        gap_ticks;
    logic signed [31:0] scale_reciprocal;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic div_step;
    logic mul;
    logic sat;
    logic fin_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic tare;
  } sts_t;

endpackage

// ===== rtl/lcar_ctrl.sv =====
// Sequencing controller: tick acceptance, divide, multiply and result hand-off.
module lcar_ctrl import lcar_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  ctrl_state_t st_r, st_nxt;
  logic        ov_r, ov_nxt;
  logic        room;

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_RUN;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Advance sequence and drive commands
  always_comb begin
    room     = !ov_r || !out_stall;
    st_nxt   = st_r;
    cmd      = '0;
    in_stall = 1'b1;
    unique case (st_r)
      C_RUN: begin
        in_stall = !room;
        if (in_valid && room) begin
          cmd.tick = 1'b1;
          if (sts.last) st_nxt = C_DIV;
        end
      end
      C_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) st_nxt = sts.tare ? C_FIN : C_MUL;
      end
      C_MUL: begin
        cmd.mul = 1'b1;
        st_nxt  = C_SAT;
      end
      C_SAT: begin
        cmd.sat = 1'b1;
        st_nxt  = C_FIN;
      end
      C_FIN: begin
        if (room) begin
          cmd.fin_load = 1'b1;
          st_nxt       = C_RUN;
        end
      end
      default: st_nxt = C_RUN;
    endcase
    if ((cmd.tick && !sts.last) || cmd.fin_load) ov_nxt = 1'b1;
    else if (!out_stall)                          ov_nxt = 1'b0;
    else                                          ov_nxt = ov_r;
  end

  assign out_valid = ov_r;

endmodule

// ===== rtl/lcar_dp.sv =====
// Datapath: serial clock timing, bit capture, accumulate, divide, scale, output register.
module lcar_dp import lcar_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_mode,
  input  logic               in_dout_level,
  output logic               out_sck_level,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [23:0]        out_raw_average,
  output logic signed [31:0] out_weight,
  output logic               out_timed_out
);

  phase_t              ph_r, ph_nxt;
  logic [4:0]          bc_r, bc_nxt;
  logic [23:0]         sh_r, sh_nxt;
  logic [19:0]         tc_r, tc_nxt;
  logic [10:0]         sd_r, sd_nxt;
  logic [SumW-1:0]     sum_r, sum_nxt;
  logic [23:0]         tare_r;
  logic                dt_r, dt_nxt;
  logic [23:0]         avg_r;
  logic signed [31:0]  wt_r;
  logic                to_r, to_nxt;
  logic [SumW-1:0]     dq_r;
  logic [10:0]         rem_r;
  logic [DivCntW-1:0]  dcnt_r;
  logic signed [ProdW-1:0] prod_r;

  logic [20:0]         tc_inc;
  logic [9:0]          half;
  logic [19:0]         tmo;
  logic [10:0]         neff;
  logic [4:0]          pulses;
  logic [4:0]          bc_inc;
  logic                fin, last, sck;
  logic [23:0]         fval;
  logic [11:0]         dshift;
  logic                dge;
  logic signed [24:0]  diff;
  logic signed [ProdW-1:0]  prod_sh;
  logic signed [ProdW-17:0] shr;

  // Effective settings
  always_comb begin
    half   = (cfg.half_period_ticks == '0) ? 10'd1 : cfg.half_period_ticks;
    tmo    = (cfg.ready_timeout_ticks == '0) ? 20'd1 : cfg.ready_timeout_ticks;
    if (cfg.sample_count == '0)                  neff = 11'd1;
    else if (cfg.sample_count > 11'(MaxSamples)) neff = 11'(MaxSamples);
    else                                         neff = cfg.sample_count;
    pulses = 5'(DataBits) + (cfg.use_channel_b ? 5'd2 : 5'd1);
  end

  // Per-tick phase logic
  always_comb begin
    ph_nxt  = ph_r;
    bc_nxt  = bc_r;
    sh_nxt  = sh_r;
    tc_nxt  = tc_r;
    sd_nxt  = sd_r;
    sum_nxt = sum_r;
    dt_nxt  = dt_r;
    to_nxt  = to_r;
    tc_inc  = {1'b0, tc_r} + 21'd1;
    bc_inc  = bc_r + 5'd1;
    fin     = 1'b0;
    fval    = '0;
    sck     = 1'b0;
    last    = 1'b0;
    unique case (ph_r)
      PH_IDLE: begin
        if (in_mode == ModeMeasure || in_mode == ModeTare) begin
          dt_nxt  = (in_mode == ModeTare);
          sum_nxt = '0;
          sd_nxt  = '0;
          bc_nxt  = '0;
          sh_nxt  = '0;
          tc_nxt  = '0;
          to_nxt  = 1'b0;
          ph_nxt  = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!in_dout_level) begin
          bc_nxt = '0;
          sh_nxt = '0;
          tc_nxt = '0;
          ph_nxt = PH_HIGH;
        end else begin
          tc_nxt = tc_inc[19:0];
          if (tc_inc >= {1'b0, tmo}) begin
            to_nxt = 1'b1;
            fin    = 1'b1;
          end
        end
      end
      PH_HIGH: begin
        sck = 1'b1;
        if (tc_inc >= 21'(half)) begin
          tc_nxt = '0;
          ph_nxt = PH_LOW;
        end else begin
          tc_nxt = tc_inc[19:0];
        end
      end
      PH_LOW: begin
        if (tc_inc >= 21'(half)) begin
          tc_nxt = '0;
          if (bc_r < 5'(DataBits)) sh_nxt = {sh_r[22:0], in_dout_level};
          if (bc_inc >= pulses) begin
            bc_nxt = '0;
            fin    = 1'b1;
            fval   = sh_nxt ^ SignFlip;
          end else begin
            bc_nxt = bc_inc;
            ph_nxt = PH_HIGH;
          end
        end else begin
          tc_nxt = tc_inc[19:0];
        end
      end
      PH_GAP: begin
        if (tc_inc >= {1'b0, cfg.gap_ticks}) begin
          tc_nxt = '0;
          ph_nxt = PH_WAIT;
        end else begin
          tc_nxt = tc_inc[19:0];
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
    // Close one conversion
    if (fin) begin
      sum_nxt = sum_r + SumW'(fval);
      sd_nxt  = sd_r + 11'd1;
      tc_nxt  = '0;
      last    = (sd_nxt >= neff);
      if (last)                        ph_nxt = PH_IDLE;
      else if (cfg.gap_ticks == '0)    ph_nxt = PH_WAIT;
      else                             ph_nxt = PH_GAP;
    end
  end

  // One restoring divide step; offset difference and product shift
  always_comb begin
    dshift  = {rem_r, dq_r[SumW-1]};
    dge     = (dshift >= {1'b0, neff});
    diff    = $signed({1'b0, dq_r[23:0]}) - $signed({1'b0, tare_r});
    prod_sh = prod_r >>> 16;
    shr     = prod_sh[ProdW-17:0];
  end

  assign sts.last     = last;
  assign sts.div_last = (dcnt_r == DivCntW'(1));
  assign sts.tare     = dt_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      bc_r   <= '0;
      sh_r   <= '0;
      tc_r   <= '0;
      sd_r   <= '0;
      sum_r  <= '0;
      tare_r <= '0;
      dt_r   <= 1'b0;
      avg_r  <= '0;
      wt_r   <= '0;
      to_r   <= 1'b0;
    end else begin
      if (cmd.tick) begin
        ph_r  <= ph_nxt;
        bc_r  <= bc_nxt;
        sh_r  <= sh_nxt;
        tc_r  <= tc_nxt;
        sd_r  <= sd_nxt;
        sum_r <= sum_nxt;
        dt_r  <= dt_nxt;
        to_r  <= to_nxt;
      end
      if (cmd.mul) avg_r <= dq_r[23:0];
      if (cmd.sat) begin
        if (shr > 41'sh7FFFFFFF)        wt_r <= 32'sh7FFFFFFF;
        else if (shr < -41'sh80000000)  wt_r <= 32'sh80000000;
        else                            wt_r <= shr[31:0];
      end
      if (cmd.fin_load && dt_r) tare_r <= dq_r[23:0];
    end
  end

  // Divider and multiplier working registers
  always_ff @(posedge clk) begin
    if (cmd.tick && last) begin
      dq_r   <= sum_nxt;
      rem_r  <= '0;
      dcnt_r <= DivCntW'(DivSteps);
    end else if (cmd.div_step) begin
      rem_r  <= dge ? 11'(dshift - {1'b0, neff}) : dshift[10:0];
      dq_r   <= {dq_r[SumW-2:0], dge};
      dcnt_r <= dcnt_r - DivCntW'(1);
    end
    if (cmd.mul) prod_r <= ProdW'(diff * cfg.scale_reciprocal);
  end

  // Output transaction register
  always_ff @(posedge clk) begin
    if (cmd.tick && !last) begin
      out_sck_level   <= sck;
      out_busy_res    <= (ph_nxt != PH_IDLE);
      out_done_res    <= 1'b0;
      out_raw_average <= avg_r;
      out_weight      <= wt_r;
      out_timed_out   <= to_nxt;
    end else if (cmd.fin_load) begin
      out_sck_level   <= 1'b0;
      out_busy_res    <= 1'b0;
      out_done_res    <= 1'b1;
      out_raw_average <= avg_r;
      out_weight      <= wt_r;
      out_timed_out   <= to_r;
    end
  end

endmodule

// ===== rtl/load_cell_adc_reader.sv =====
// Ordinary tick: result registered, valid in the cycle after it is taken.
// A closing tick runs the 35-step divider, multiply, saturate and load; a
// tare skips multiply and saturate. Else one tick per cycle unless the output
// stalls. Throughput is set by the bit-serial divider on finishing ticks.
// Synchronous active-low reset: idle phase, zero offset/average/weight,
// registers at their defaults; no result pending.
module load_cell_adc_reader import lcar_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic               in_dout_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_sck_level,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [23:0]        out_raw_average,
  output logic signed [31:0] out_weight,
  output logic               out_timed_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_channel_b       <= 1'b0;
      cfg_r.sample_count        <= 11'd1;
      cfg_r.half_period_ticks   <= 10'd4;
      cfg_r.ready_timeout_ticks <= 20'd150000;
      cfg_r.gap_ticks           <= 20'd5000;
      cfg_r.scale_reciprocal    <= 32'sd65536;
    end else if (wr_en) begin
      case (paddr[4:2])
        RegChanB:   cfg_r.use_channel_b       <= pwdata[0];
        RegSamples: cfg_r.sample_count        <= pwdata[10:0];
        RegHalf:    cfg_r.half_period_ticks   <= pwdata[9:0];
        RegTimeout: cfg_r.ready_timeout_ticks <= pwdata[19:0];
        RegGap:     cfg_r.gap_ticks           <= pwdata[19:0];
        RegScale:   cfg_r.scale_reciprocal    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[4:2])
      RegChanB:   prdata = {31'd0, cfg_r.use_channel_b};
      RegSamples: prdata = {21'd0, cfg_r.sample_count};
      RegHalf:    prdata = {22'd0, cfg_r.half_period_ticks};
      RegTimeout: prdata = {12'd0, cfg_r.ready_timeout_ticks};
      RegGap:     prdata = {12'd0, cfg_r.gap_ticks};
      RegScale:   prdata = cfg_r.scale_reciprocal;
      default:    prdata = '0;
    endcase
  end

  lcar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcar_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_dout_level   (in_dout_level),
    .out_sck_level   (out_sck_level),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_raw_average (out_raw_average),
    .out_weight      (out_weight),
    .out_timed_out   (out_timed_out)
  );

endmodule

// ===== rtl/lcar_checker.sv =====
// Port-level checker for the load cell converter reader, with its bind.
module lcar_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_sck_level,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [31:0] out_weight
);

  // Stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_weight))
    else $error("stalled result changed");

  // Finish transaction reports idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done while busy");

  // Clock pin low on finish
  a_done_sck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_sck_level)
    else $error("clock high on finish");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind load_cell_adc_reader lcar_checker u_lcar_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sck_level (out_sck_level),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_weight    (out_weight)
);

// ===== dv/load_cell_adc_reader_test.sv =====
// Self-checking testbench for the load cell converter reader: directed and random ticks.
`timescale 1ns / 1ps

module load_cell_adc_reader_test;
  import lcar_pkg::*;

  typedef struct packed {
    logic               sck;
    logic               busy;
    logic               done;
    logic [23:0]        avg;
    logic signed [31:0] weight;
    logic               tmo;
  } tick_res_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       dout;
    logic       typed;
    tick_res_t  res;
  } tick_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = ModeTick;
  logic               in_dout_level = 1'b1;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_sck_level;
  logic               out_busy_res;
  logic               out_done_res;
  logic [23:0]        out_raw_average;
  logic signed [31:0] out_weight;
  logic               out_timed_out;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Model copy of the registers and state
  logic               m_chan_b;
  logic [10:0]        m_samples;
  logic [9:0]         m_half;
  logic [19:0]        m_tmo;
  logic [19:0]        m_gap;
  logic signed [31:0] m_scale;
  phase_t             m_phase;
  logic [4:0]         m_bits;
  logic [23:0]        m_shift;
  logic [19:0]        m_ticks;
  logic [10:0]        m_done_cnt;
  logic [34:0]        m_sum;
  logic [23:0]        m_offset;
  logic               m_tare;
  logic [23:0]        m_avg;
  logic signed [31:0] m_weight;
  logic               m_tmo_seen;

  tick_res_t pending_ticks[$];
  bit        failed = 1'b0;
  bit        jitter_on = 1'b1;
  int        stall_left = 0;
  int        dout_low_pct = 50;

  load_cell_adc_reader dut (.*);

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [10:0] eff_samples();
    if (m_samples == 0) return 11'd1;
    if (m_samples > MaxSamples) return 11'(MaxSamples);
    return m_samples;
  endfunction

  // Close one conversion; returns 1 when the whole operation is over
  function automatic bit close_sample(logic [23:0] value);
    logic [23:0]        avg;
    logic signed [24:0] diff;
    logic signed [56:0] prod;
    logic signed [56:0] w;
    m_sum = m_sum + 35'(value);
    m_done_cnt = m_done_cnt + 11'd1;
    m_ticks = '0;
    if (m_done_cnt >= eff_samples()) begin
      avg = 24'(m_sum / eff_samples());
      if (m_tare) begin
        m_offset = avg;
      end else begin
        diff = $signed({1'b0, avg}) - $signed({1'b0, m_offset});
        prod = 57'(diff) * 57'(m_scale);
        w = prod >>> 16;
        if (w > 57'sd2147483647) w = 57'sd2147483647;
        if (w < -57'sd2147483648) w = -57'sd2147483648;
        m_avg = avg;
        m_weight = w[31:0];
      end
      m_phase = PH_IDLE;
      return 1'b1;
    end
    m_phase = (m_gap == 0) ? PH_WAIT : PH_GAP;
    return 1'b0;
  endfunction

  // Advance the model by one tick and return the result it predicts
  function automatic tick_res_t step_tick(logic [1:0] mode, logic dout);
    tick_res_t   r;
    logic [19:0] half;
    logic [19:0] tmo;
    logic [4:0]  pulses;
    bit          fin;
    half = (m_half == 0) ? 20'd1 : 20'(m_half);
    tmo = (m_tmo == 0) ? 20'd1 : m_tmo;
    pulses = m_chan_b ? 5'd26 : 5'd25;
    fin = 1'b0;
    r.sck = 1'b0;
    case (m_phase)
      PH_IDLE: begin
        if (mode == ModeMeasure || mode == ModeTare) begin
          m_tare = (mode == ModeTare);
          m_sum = '0;
          m_done_cnt = '0;
          m_bits = '0;
          m_shift = '0;
          m_ticks = '0;
          m_tmo_seen = 1'b0;
          m_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!dout) begin
          m_bits = '0;
          m_shift = '0;
          m_ticks = '0;
          m_phase = PH_HIGH;
        end else begin
          m_ticks = m_ticks + 20'd1;
          if (m_ticks >= tmo) begin
            m_tmo_seen = 1'b1;
            fin = close_sample(24'd0);
          end
        end
      end
      PH_HIGH: begin
        r.sck = 1'b1;
        m_ticks = m_ticks + 20'd1;
        if (m_ticks >= half) begin
          m_ticks = '0;
          m_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        m_ticks = m_ticks + 20'd1;
        if (m_ticks >= half) begin
          m_ticks = '0;
          if (m_bits < DataBits) m_shift = {m_shift[22:0], dout};
          m_bits = m_bits + 5'd1;
          if (m_bits >= pulses) begin
            m_bits = '0;
            fin = close_sample(m_shift ^ SignFlip);
          end else begin
            m_phase = PH_HIGH;
          end
        end
      end
      PH_GAP: begin
        m_ticks = m_ticks + 20'd1;
        if (m_ticks >= m_gap) begin
          m_ticks = '0;
          m_phase = PH_WAIT;
        end
      end
      default: m_phase = PH_IDLE;
    endcase
    r.busy = (m_phase != PH_IDLE);
    r.done = fin;
    r.avg = m_avg;
    r.weight = m_weight;
    r.tmo = m_tmo_seen;
    return r;
  endfunction

  // Send one tick; typed rows carry their own expectation
  task automatic send_tick(logic [1:0] mode, logic dout, bit typed = 0,
                           tick_res_t typed_res = '0);
    tick_res_t r;
    int        k;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_dout_level <= dout;
    do @(posedge clk); while (in_stall);
    r = step_tick(mode, dout);
    pending_ticks.push_back(typed ? typed_res : r);
    if (jitter_on && $urandom_range(0, 15) == 0) begin
      k = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  // Random tick shaped by the model phase
  task automatic send_random();
    logic [1:0] mode;
    logic       dout;
    int         pick;
    pick = $urandom_range(0, 99);
    if (m_phase == PH_IDLE)
      mode = (pick < 60) ? (pick < 35 ? ModeMeasure : ModeTare) : 2'($urandom_range(0, 3));
    else
      mode = (pick < 90) ? ModeTick : 2'($urandom_range(0, 3));
    if (m_phase == PH_WAIT) dout = ($urandom_range(0, 99) >= dout_low_pct);
    else dout = 1'($urandom_range(0, 1));
    send_tick(mode, dout);
  endtask

  // Finish the operation, then hold until every result is back
  task automatic drain();
    logic dout;
    while (m_phase != PH_IDLE) begin
      // Let a short wait time out, otherwise report ready at once
      dout = (m_phase == PH_WAIT) && (m_tmo <= 20'd8);
      send_tick(ModeTick, dout);
    end
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegChanB:   m_chan_b = value[0];
      RegSamples: m_samples = value[10:0];
      RegHalf:    m_half = value[9:0];
      RegTimeout: m_tmo = value[19:0];
      RegGap:     m_gap = value[19:0];
      RegScale:   m_scale = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic chb, logic [31:0] n, logic [31:0] half,
                            logic [31:0] tmo, logic [31:0] gap, logic [31:0] scale);
    reg_write(RegChanB, {31'd0, chb});
    reg_write(RegSamples, n);
    reg_write(RegHalf, half);
    reg_write(RegTimeout, tmo);
    reg_write(RegGap, gap);
    reg_write(RegScale, scale);
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left <= stall_left - 1;
    else if (jitter_on && $urandom_range(0, 11) == 0) stall_left <= $urandom_range(1, 7);
  end
  always @(posedge clk) begin
    out_stall <= jitter_on && (stall_left > 1 || (stall_left == 0 && $urandom_range(0, 11) == 0));
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    tick_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ticks.size() == 0) begin
        $display("%0t: result transaction with no expectation waiting", $realtime);
        failed = 1'b1;
      end else begin
        e = pending_ticks.pop_front();
        check_field("sck_level", e.sck, out_sck_level);
        check_field("busy_res", e.busy, out_busy_res);
        check_field("done_res", e.done, out_done_res);
        check_field("raw_average", e.avg, out_raw_average);
        check_field("weight", e.weight, out_weight);
        check_field("timed_out", e.tmo, out_timed_out);
      end
    end
  end

  initial begin
    tick_row_t rows[$];
    m_chan_b = 1'b0;
    m_samples = 11'd1;
    m_half = 10'd4;
    m_tmo = 20'd150000;
    m_gap = 20'd5000;
    m_scale = 32'sd65536;
    m_phase = PH_IDLE;
    m_bits = '0;
    m_shift = '0;
    m_ticks = '0;
    m_done_cnt = '0;
    m_sum = '0;
    m_offset = '0;
    m_tare = 1'b0;
    m_avg = '0;
    m_weight = '0;
    m_tmo_seen = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ticks, unused mode, start, requests while busy, a sample
    rows.push_back('{ModeTick, 1'b1, 1'b1, '0});
    rows.push_back('{ModeSpare, 1'b0, 1'b1, '0});
    rows.push_back('{ModeTick, 1'b0, 1'b1, '0});
    rows.push_back('{ModeMeasure, 1'b1, 1'b1, tick_res_t'({1'b0, 1'b1, 1'b0, 24'd0, 32'd0, 1'b0})});
    rows.push_back('{ModeTare, 1'b1, 1'b0, '0});
    rows.push_back('{ModeMeasure, 1'b1, 1'b0, '0});
    rows.push_back('{ModeTick, 1'b1, 1'b0, '0});
    rows.push_back('{ModeTick, 1'b0, 1'b0, '0});
    for (int i = 0; i < 16; i++) rows.push_back('{ModeTick, 1'(i % 3 == 0), 1'b0, '0});
    foreach (rows[i]) send_tick(rows[i].mode, rows[i].dout, rows[i].typed, rows[i].res);
    drain();

    // Fast clocking, tares and measurements
    set_config(1'b0, 1, 1, 3, 0, 32'h0001_0000);
    repeat (120) send_random();
    drain();
    set_config(1'b1, 3, 2, 5, 2, $urandom());
    repeat (120) send_random();
    drain();
    // Zero sample count, half period and timeout act as one; saturating scale
    dout_low_pct = 30;
    set_config(1'b1, 0, 0, 0, 0, 32'h7FFF_FFFF);
    repeat (80) send_random();
    drain();
    // Most negative scale, timeouts on nearly every sample
    dout_low_pct = 5;
    set_config(1'b0, 16, 1, 1, 0, 32'h8000_0000);
    repeat (80) send_random();
    drain();
    // Widest sample count, half period and gap written, then waits that never time out
    dout_low_pct = 100;
    set_config(1'b0, 2047, 1023, 3, 1048575, 32'hFFFF_FFFF);
    reg_write(RegSamples, 32'd1);
    repeat (30) send_random();
    drain();
    // Closing stretch with no idling on either side
    dout_low_pct = 50;
    jitter_on = 1'b0;
    set_config(1'b1, 2, 1, 4, 3, $urandom());
    repeat (120) send_random();
    drain();

    if (!failed && pending_ticks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lcar_pkg.sv
rtl/lcar_ctrl.sv
rtl/lcar_dp.sv
rtl/load_cell_adc_reader.sv
rtl/lcar_checker.sv
dv/load_cell_adc_reader_test.sv
